@@ src/pce_pkg.sv @@
`default_nettype none

package pce_pkg;

  // Channel width of one color component
  localparam int unsigned ChanW = 8;

  // Effect selection codes; unused codes pass the pixel through
  typedef enum logic [3:0] {
    MODE_NONE     = 4'd0,
    MODE_SEPIA    = 4'd1,
    MODE_NEGATIVE = 4'd2,
    MODE_VINTAGE  = 4'd3,
    MODE_RED      = 4'd4,
    MODE_GREEN    = 4'd5,
    MODE_BLUE     = 4'd6,
    MODE_POSTER   = 4'd7,
    MODE_THERMAL  = 4'd8
  } effect_mode_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Sepia matrix, Q0.10, one row per output channel
  localparam logic [9:0] SepRr = 10'd402;
  localparam logic [9:0] SepRg = 10'd787;
  localparam logic [9:0] SepRb = 10'd194;
  localparam logic [9:0] SepGr = 10'd357;
  localparam logic [9:0] SepGg = 10'd702;
  localparam logic [9:0] SepGb = 10'd172;
  localparam logic [9:0] SepBr = 10'd279;
  localparam logic [9:0] SepBg = 10'd547;
  localparam logic [9:0] SepBb = 10'd134;

  // Vintage gains (Q0.8) and offsets
  localparam logic [7:0] VinGainR = 8'd230;
  localparam logic [7:0] VinGainG = 8'd218;
  localparam logic [7:0] VinGainB = 8'd205;
  localparam logic [7:0] VinOffR  = 8'd20;
  localparam logic [7:0] VinOffG  = 8'd15;
  localparam logic [7:0] VinOffB  = 8'd10;

  // Posterize keeps the top two bits
  localparam logic [7:0] PosterMask = 8'hC0;

  // Thermal band edges on s = r + g + b
  localparam logic [9:0] ThermLow  = 10'd255;
  localparam logic [9:0] ThermMid  = 10'd510;
  localparam logic [9:0] ThermFull = 10'd765;

endpackage

`default_nettype wire

@@ src/pce_effect.sv @@
`default_nettype none

module pce_effect
  import pce_pkg::*;
(
  input  effect_mode_e mode_i,
  input  pixel_t       pix_i,
  output pixel_t       pix_o
);

  logic [18:0] sep_r_sum, sep_g_sum, sep_b_sum;
  logic [8:0]  sep_r, sep_g, sep_b;
  logic [8:0]  vin_r, vin_g, vin_b;
  logic [8:0]  tint_r, tint_g, tint_b;
  logic [9:0]  therm_s;
  logic [9:0]  therm_lo, therm_hi;

  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  // Products widened to 19 bits; the largest row sum, 1383 x 255, fits
  function automatic logic [18:0] mac3(input logic [7:0] a, input logic [9:0] ca,
                                       input logic [7:0] b, input logic [9:0] cb,
                                       input logic [7:0] c, input logic [9:0] cc);
    return (19'(a) * 19'(ca)) + (19'(b) * 19'(cb)) + (19'(c) * 19'(cc));
  endfunction

  function automatic logic [8:0] vint(input logic [7:0] x, input logic [7:0] gain,
                                      input logic [7:0] off);
    logic [15:0] prod;
    prod = 16'(x) * 16'(gain);
    return 9'(prod[15:8]) + 9'(off);
  endfunction

  function automatic logic [8:0] tint(input logic [7:0] x);
    logic [9:0] x3;
    x3 = 10'(x) + {1'b0, x, 1'b0};
    return x3[9:1];
  endfunction

  // Sepia matrix
  assign sep_r_sum = mac3(pix_i.red, SepRr, pix_i.green, SepRg, pix_i.blue, SepRb);
  assign sep_g_sum = mac3(pix_i.red, SepGr, pix_i.green, SepGg, pix_i.blue, SepGb);
  assign sep_b_sum = mac3(pix_i.red, SepBr, pix_i.green, SepBg, pix_i.blue, SepBb);
  assign sep_r = sep_r_sum[18:10];
  assign sep_g = sep_g_sum[18:10];
  assign sep_b = sep_b_sum[18:10];

  // Vintage gain and offset
  assign vin_r = vint(pix_i.red,   VinGainR, VinOffR);
  assign vin_g = vint(pix_i.green, VinGainG, VinOffG);
  assign vin_b = vint(pix_i.blue,  VinGainB, VinOffB);

  // Tint by 1.5
  assign tint_r = tint(pix_i.red);
  assign tint_g = tint(pix_i.green);
  assign tint_b = tint(pix_i.blue);

  // Thermal sum and band offsets
  assign therm_s  = 10'(pix_i.red) + 10'(pix_i.green) + 10'(pix_i.blue);
  assign therm_lo = therm_s - ThermLow;
  assign therm_hi = ThermFull - therm_s;

  // Select the effect
  always_comb begin
    pix_o = pix_i;
    case (mode_i)
      MODE_SEPIA: begin
        pix_o.red   = sat8(sep_r);
        pix_o.green = sat8(sep_g);
        pix_o.blue  = sat8(sep_b);
      end
      MODE_NEGATIVE: begin
        pix_o.red   = ~pix_i.red;
        pix_o.green = ~pix_i.green;
        pix_o.blue  = ~pix_i.blue;
      end
      MODE_VINTAGE: begin
        pix_o.red   = sat8(vin_r);
        pix_o.green = sat8(vin_g);
        pix_o.blue  = sat8(vin_b);
      end
      MODE_RED:   pix_o.red   = sat8(tint_r);
      MODE_GREEN: pix_o.green = sat8(tint_g);
      MODE_BLUE:  pix_o.blue  = sat8(tint_b);
      MODE_POSTER: begin
        pix_o.red   = pix_i.red   & PosterMask;
        pix_o.green = pix_i.green & PosterMask;
        pix_o.blue  = pix_i.blue  & PosterMask;
      end
      MODE_THERMAL: begin
        if (therm_s < ThermLow) begin
          pix_o.red   = 8'd0;
          pix_o.green = 8'd0;
          pix_o.blue  = therm_s[7:0];
        end else if (therm_s < ThermMid) begin
          pix_o.red   = therm_lo[7:0];
          pix_o.green = 8'hFF;
          pix_o.blue  = 8'hFF;
        end else begin
          pix_o.red   = 8'hFF;
          pix_o.green = therm_hi[7:0];
          pix_o.blue  = 8'd0;
        end
      end
      default: pix_o = pix_i;
    endcase
  end

endmodule

`default_nettype wire

@@ src/pixel_color_effect_core.sv @@
// Per-pixel RGB color effect. Each accepted pixel yields exactly one recolored
// pixel, which passes through the input register and then the output
// register before it shows on the output, and one pixel is taken every
// clock while the output is not stalled: an input register feeds the effect
// datapath, whose result lands in an output register, so throughput is one
// pixel per cycle without a stall; the sepia multiply-add is the longest path
// between the two registers. The effect is chosen by effect_mode through the
// cfg port (0 none, 1 sepia, 2 negative, 3 vintage, 4/5/6 red/green/blue tint,
// 7 posterize, 8 thermal; other codes pass through). Write it only while no
// pixel is in flight; cfg_ready_o is always high.
`default_nettype none

module pixel_color_effect_core
  import pce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);

  effect_mode_e mode_q;
  logic         in_valid_q, in_valid_d;
  pixel_t       in_pix_q;
  logic         out_valid_q, out_valid_d;
  pixel_t       out_pix_q;
  pixel_t       fx_pix;
  logic         adv;

  // Mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else if (cfg_valid_i) begin
      mode_q <= effect_mode_e'(cfg_data_i);
    end
  end

  // Advance the input stage when the output register is free or draining
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || adv;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = adv ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_pix_q <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
    end
  end

  pce_effect u_effect (
    .mode_i (mode_q),
    .pix_i  (in_pix_q),
    .pix_o  (fx_pix)
  );

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      out_pix_q <= fx_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q.red;
  assign green_out_o = out_pix_q.green;
  assign blue_out_o  = out_pix_q.blue;

endmodule

`default_nettype wire

@@ src/pce_checker.sv @@
`default_nettype none

module pce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o)))
    else $error("result changed while stalled");

  // Drop input ready only when the output side is backed up
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // An accepted transaction is followed by a valid result on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##1 out_valid_o)
    else $error("no result after accepted transaction");

endmodule

bind pixel_color_effect_core pce_checker u_pce_checker (.*);

`default_nettype wire
